[rtl/core/bmp_rle_pixel_decoder_top_defines.svh]
// Assertion macros for the BMP RLE pixel decoder.
// Used by the top level; the enclosing module must have clk and rst_n.
`ifndef BMP_RLE_PIXEL_DECODER_TOP_DEFINES_SVH
`define BMP_RLE_PIXEL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define BMPRLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BMPRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bmprle_pkg.sv]
// Shared types and constants for the BMP RLE pixel decoder.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package bmprle_pkg;

  localparam int DIM_W       = 13;
  localparam int ADDR_W      = 24;
  localparam int RGB_W       = 24;
  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;

  // Second byte of an escape pair.
  localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
  localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

  typedef enum logic [1:0] {
    ACT_PAL   = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_FRAME = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SECOND = 3'd1,
    PH_DX     = 3'd2,
    PH_DY     = 3'd3,
    PH_ABS    = 3'd4,
    PH_PAD    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    Q_PAL  = 2'd0,
    Q_SEG  = 2'd1,
    Q_DONE = 2'd2
  } qkind_t;

  // One queue word from the parser to the palette stage.
  typedef struct packed {
    qkind_t              kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   len;
    logic [PAL_AW-1:0]   idx_e;
    logic [PAL_AW-1:0]   idx_o;
    logic [RGB_W-1:0]    rgb;
  } qent_t;

  typedef struct packed {
    phase_t phase;
    logic   finished;
  } fstat_t;

endpackage

`default_nettype wire

[rtl/core/bmprle_if.sv]
// Channel interfaces of the BMP RLE pixel decoder: input, result and configuration.
// Depends on bmprle_pkg for field widths.
`default_nettype none

interface bmprle_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [bmprle_pkg::BYTE_W-1:0]     stream_byte;
  logic [bmprle_pkg::PAL_AW-1:0]     palette_index;
  logic [bmprle_pkg::RGB_W-1:0]      palette_rgb;

  modport source (output valid, action, stream_byte, palette_index, palette_rgb,
                  input ready);
  modport sink (input valid, action, stream_byte, palette_index, palette_rgb,
                output ready);
endinterface

interface bmprle_out_if;
  logic                              valid;
  logic                              ready;
  logic [bmprle_pkg::ADDR_W-1:0]     start_address;
  logic [bmprle_pkg::BYTE_W-1:0]     run_length;
  logic [bmprle_pkg::RGB_W-1:0]      color_even;
  logic [bmprle_pkg::RGB_W-1:0]      color_odd;
  logic                              frame_done;

  modport source (output valid, start_address, run_length, color_even, color_odd,
                  frame_done, input ready);
  modport sink (input valid, start_address, run_length, color_even, color_odd,
                frame_done, output ready);
endinterface

interface bmprle_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bmprle_pkg::CFG_IDX_W-1:0]    index;
  logic [bmprle_pkg::DIM_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/bmp_rle_pixel_decoder_top.sv]
// BMP RLE8/RLE4 pixel decoder, top level.
// Channels: in_if takes one word per item (palette load, stream byte or frame start),
// cfg_if writes rle4_mode, image_width and image_height by index, and out_if
// returns pixel segments and the end-of-frame word. All use valid/ready; a word
// moves at a rising edge with both high. cfg_if is always ready; the user must
// write it only while the block is idle, which the block itself does not enforce.
// Throughput is one input word per cycle while the queue is not full. The parser
// handles each byte, including the row-times-width multiply of end of line and
// delta; a four-word queue feeds the palette stage, which reads both colors at
// once. A result passes through the queue and the result register to out_if.
// When out_if stalls, the result register holds, the queue fills, and in_ready
// falls once four words are waiting. A palette load at the head still drains.
// Reset (rst_n low at a rising edge) clears the parse position, the queue and
// the result valid flag and sets the registers to RLE8, width 1, height 1; the
// palette is not cleared, and entries must be loaded before they are used.
// Depends on bmprle_pkg, bmprle_if, bmprle_front, bmprle_queue, bmprle_back.
`default_nettype none
`include "bmp_rle_pixel_decoder_top_defines.svh"

module bmp_rle_pixel_decoder_top (
  input  logic           clk,
  input  logic           rst_n,
  bmprle_in_if.sink      in_if,
  bmprle_cfg_if.sink     cfg_if,
  bmprle_out_if.source   out_if
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  bmprle_pkg::qent_t   q_ent;
  bmprle_pkg::qent_t   q_head;
  bmprle_pkg::fstat_t  fstat;

  bmprle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_ent  (q_ent),
    .stat   (fstat)
  );

  bmprle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  bmprle_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

  `BMPRLE_ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "queue push while full")
  `BMPRLE_ASSERT_NEXT(a_frame_start_clears, in_if.valid && in_if.ready && in_if.action == bmprle_pkg::ACT_FRAME, fstat.phase == bmprle_pkg::PH_FIRST && !fstat.finished, "frame start did not clear the parser")
  `BMPRLE_ASSERT_SAME(a_result_from_queue, $rose(out_if.valid), $past(q_pop), "result appeared without a queue pop")

endmodule

`default_nettype wire

[rtl/core/bmprle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bmprle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/bmprle_front.sv]
// Stream parser: configuration registers, pair/escape/absolute parsing and pixel addressing.
// Depends on bmprle_pkg and bmprle_if; pushes one word per result and per palette load into the queue.
`default_nettype none

module bmprle_front (
  input  logic                clk,
  input  logic                rst_n,
  bmprle_in_if.sink           in_if,
  bmprle_cfg_if.sink          cfg_if,
  input  logic                q_full,
  output logic                q_push,
  output bmprle_pkg::qent_t   q_ent,
  output bmprle_pkg::fstat_t  stat
);

  logic                               mode_r;
  logic [bmprle_pkg::DIM_W-1:0]       width_r;
  logic [bmprle_pkg::DIM_W-1:0]       height_r;

  bmprle_pkg::phase_t                 phase_r, phase_nxt;
  logic [bmprle_pkg::BYTE_W-1:0]      held_r, held_nxt;
  logic [bmprle_pkg::BYTE_W-1:0]      abs_r, abs_nxt;
  logic                               pad_r, pad_nxt;
  logic [bmprle_pkg::DIM_W-1:0]       col_r, col_nxt;
  logic [bmprle_pkg::DIM_W-1:0]       row_r, row_nxt;
  logic [bmprle_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic                               fin_r, fin_nxt;

  logic                               accept;
  logic                               pal_go;
  logic                               frame_go;
  logic                               byte_go;
  logic [bmprle_pkg::BYTE_W-1:0]      b;
  logic [bmprle_pkg::BYTE_W:0]        b_inc;
  logic [bmprle_pkg::PAL_AW-1:0]      hi_idx;
  logic [bmprle_pkg::PAL_AW-1:0]      lo_idx;
  logic [bmprle_pkg::BYTE_W-1:0]      abs_n;
  logic [bmprle_pkg::BYTE_W-1:0]      abs_rem;
  logic [bmprle_pkg::BYTE_W-1:0]      seg_len;

  logic [bmprle_pkg::DIM_W:0]         mv_row_ext;
  logic [bmprle_pkg::DIM_W-1:0]       mv_col;
  logic [2*bmprle_pkg::DIM_W-1:0]     mv_prod;
  logic [bmprle_pkg::ADDR_W-1:0]      mv_addr;
  logic                               mv_end;

  assign in_if.ready  = !q_full;
  assign cfg_if.ready = 1'b1;

  assign accept   = in_if.valid && !q_full;
  assign pal_go   = accept && (in_if.action == bmprle_pkg::ACT_PAL);
  assign frame_go = accept && (in_if.action == bmprle_pkg::ACT_FRAME);
  assign byte_go  = accept && (in_if.action == bmprle_pkg::ACT_BYTE) && !fin_r;
  assign b        = in_if.stream_byte;
  assign b_inc    = {1'b0, b} + 9'd1;

  // In RLE4 the high nibble colors even pixels and the low nibble odd pixels.
  assign hi_idx = mode_r ? {{(bmprle_pkg::PAL_AW-bmprle_pkg::NIB_W){1'b0}},
                            b[bmprle_pkg::BYTE_W-1 -: bmprle_pkg::NIB_W]} : b;
  assign lo_idx = mode_r ? {{(bmprle_pkg::PAL_AW-bmprle_pkg::NIB_W){1'b0}},
                            b[bmprle_pkg::NIB_W-1:0]} : b;

  assign abs_n   = mode_r ? ((abs_r >= 8'd2) ? 8'd2 : abs_r) : 8'd1;
  assign abs_rem = abs_r - abs_n;
  assign seg_len = (phase_r == bmprle_pkg::PH_ABS) ? abs_n : held_r;

  // New position for end of line and delta; the end test uses the unwrapped row.
  always_comb begin
    if (phase_r == bmprle_pkg::PH_DY) begin
      mv_col     = col_r + {5'b0, held_r};
      mv_row_ext = {1'b0, row_r} + {6'b0, b};
    end else begin
      mv_col     = '0;
      mv_row_ext = {1'b0, row_r} + 14'd1;
    end
  end

  assign mv_prod = {13'b0, mv_row_ext[bmprle_pkg::DIM_W-1:0]} * {13'b0, width_r};
  assign mv_addr = mv_prod[bmprle_pkg::ADDR_W-1:0] + {11'b0, mv_col};
  assign mv_end  = mv_row_ext >= {1'b0, height_r};

  // Parse phase transitions.
  always_comb begin
    phase_nxt = phase_r;
    if (frame_go) begin
      phase_nxt = bmprle_pkg::PH_FIRST;
    end else if (byte_go) begin
      case (phase_r)
        bmprle_pkg::PH_FIRST: begin
          phase_nxt = bmprle_pkg::PH_SECOND;
        end
        bmprle_pkg::PH_SECOND: begin
          if (held_r != 8'd0) begin
            phase_nxt = bmprle_pkg::PH_FIRST;
          end else if (b == bmprle_pkg::ESC_EOL || b == bmprle_pkg::ESC_EOB) begin
            phase_nxt = bmprle_pkg::PH_FIRST;
          end else if (b == bmprle_pkg::ESC_DELTA) begin
            phase_nxt = bmprle_pkg::PH_DX;
          end else begin
            phase_nxt = bmprle_pkg::PH_ABS;
          end
        end
        bmprle_pkg::PH_DX: begin
          phase_nxt = bmprle_pkg::PH_DY;
        end
        bmprle_pkg::PH_DY: begin
          phase_nxt = bmprle_pkg::PH_FIRST;
        end
        bmprle_pkg::PH_ABS: begin
          if (abs_rem == 8'd0) begin
            phase_nxt = pad_r ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
          end
        end
        default: begin
          phase_nxt = bmprle_pkg::PH_FIRST;
        end
      endcase
    end
  end

  // Position state and queue words.
  always_comb begin
    held_nxt = held_r;
    abs_nxt  = abs_r;
    pad_nxt  = pad_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    addr_nxt = addr_r;
    fin_nxt  = fin_r;
    q_push   = 1'b0;
    q_ent    = '0;
    if (pal_go) begin
      q_push      = 1'b1;
      q_ent.kind  = bmprle_pkg::Q_PAL;
      q_ent.idx_e = in_if.palette_index;
      q_ent.rgb   = in_if.palette_rgb;
    end else if (frame_go) begin
      held_nxt = '0;
      abs_nxt  = '0;
      pad_nxt  = 1'b0;
      col_nxt  = '0;
      row_nxt  = '0;
      addr_nxt = '0;
      fin_nxt  = 1'b0;
    end else if (byte_go) begin
      case (phase_r)
        bmprle_pkg::PH_FIRST, bmprle_pkg::PH_DX: begin
          held_nxt = b;
        end
        bmprle_pkg::PH_SECOND, bmprle_pkg::PH_ABS: begin
          if (phase_r == bmprle_pkg::PH_ABS || held_r != 8'd0) begin
            q_push      = 1'b1;
            q_ent.kind  = bmprle_pkg::Q_SEG;
            q_ent.addr  = addr_r;
            q_ent.len   = seg_len;
            q_ent.idx_e = hi_idx;
            q_ent.idx_o = lo_idx;
            addr_nxt    = addr_r + {16'b0, seg_len};
            col_nxt     = col_r + {5'b0, seg_len};
            if (phase_r == bmprle_pkg::PH_ABS) begin
              abs_nxt = abs_rem;
            end
          end else if (b == bmprle_pkg::ESC_EOL) begin
            col_nxt  = mv_col;
            row_nxt  = mv_row_ext[bmprle_pkg::DIM_W-1:0];
            addr_nxt = mv_addr;
            if (mv_end) begin
              fin_nxt    = 1'b1;
              q_push     = 1'b1;
              q_ent.kind = bmprle_pkg::Q_DONE;
              q_ent.addr = mv_addr;
            end
          end else if (b == bmprle_pkg::ESC_EOB) begin
            fin_nxt    = 1'b1;
            q_push     = 1'b1;
            q_ent.kind = bmprle_pkg::Q_DONE;
            q_ent.addr = addr_r;
          end else if (b != bmprle_pkg::ESC_DELTA) begin
            abs_nxt = b;
            pad_nxt = mode_r ? b_inc[1] : b[0];
          end
        end
        bmprle_pkg::PH_DY: begin
          col_nxt  = mv_col;
          row_nxt  = mv_row_ext[bmprle_pkg::DIM_W-1:0];
          addr_nxt = mv_addr;
          if (mv_end) begin
            fin_nxt    = 1'b1;
            q_push     = 1'b1;
            q_ent.kind = bmprle_pkg::Q_DONE;
            q_ent.addr = mv_addr;
          end
        end
        bmprle_pkg::PH_PAD: begin
          pad_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= 13'd1;
      height_r <= 13'd1;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        bmprle_pkg::CFG_MODE:   mode_r   <= cfg_if.data[0];
        bmprle_pkg::CFG_WIDTH:  width_r  <= cfg_if.data;
        bmprle_pkg::CFG_HEIGHT: height_r <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bmprle_pkg::PH_FIRST;
      held_r  <= '0;
      abs_r   <= '0;
      pad_r   <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      addr_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      abs_r   <= abs_nxt;
      pad_r   <= pad_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      addr_r  <= addr_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign stat.phase    = phase_r;
  assign stat.finished = fin_r;

endmodule

`default_nettype wire

[rtl/core/bmprle_queue.sv]
// Short word queue between the parser and the palette stage.
// Depends on bmprle_pkg for the word type and depth.
`default_nettype none

module bmprle_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bmprle_pkg::qent_t  push_ent,
  input  logic               pop,
  output bmprle_pkg::qent_t  head,
  output logic               full,
  output logic               empty
);

  bmprle_pkg::qent_t                 words [bmprle_pkg::QUEUE_DEPTH];
  logic [bmprle_pkg::QPTR_W-1:0]     wr_r, wr_nxt;
  logic [bmprle_pkg::QPTR_W-1:0]     rd_r, rd_nxt;
  logic [bmprle_pkg::QPTR_W:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (bmprle_pkg::QPTR_W+1)'(bmprle_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = words[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + {{bmprle_pkg::QPTR_W{1'b0}}, push} - {{bmprle_pkg::QPTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      words[wr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bmprle_back.sv]
// Palette stage: holds the palette, looks up segment colors and drives the result register.
// Depends on bmprle_pkg, bmprle_if and bmprle_ram.
`default_nettype none

module bmprle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bmprle_pkg::qent_t  head,
  input  logic               q_empty,
  output logic               q_pop,
  bmprle_out_if.source       out_if
);

  logic                               out_valid_r, out_valid_nxt;
  logic [bmprle_pkg::ADDR_W-1:0]      addr_r;
  logic [bmprle_pkg::BYTE_W-1:0]      len_r;
  logic                               done_r;
  logic                               can_load;
  logic                               is_pal;
  logic                               is_res;
  logic                               pal_we;
  logic                               pal_re;
  logic                               load;
  logic [bmprle_pkg::RGB_W-1:0]       even_q;
  logic [bmprle_pkg::RGB_W-1:0]       odd_q;

  assign can_load = !out_valid_r || out_if.ready;
  assign is_pal   = (head.kind == bmprle_pkg::Q_PAL);
  assign is_res   = (head.kind == bmprle_pkg::Q_SEG) || (head.kind == bmprle_pkg::Q_DONE);

  // Palette writes never wait; words of an unknown kind are dropped.
  assign q_pop  = !q_empty && (!is_res || can_load);
  assign load   = q_pop && is_res;
  assign pal_we = q_pop && is_pal;
  assign pal_re = q_pop && (head.kind == bmprle_pkg::Q_SEG);

  // Two copies of the palette give the even and odd colors in the same cycle.
  bmprle_ram #(
    .WIDTH (bmprle_pkg::RGB_W),
    .DEPTH (bmprle_pkg::PAL_DEPTH)
  ) u_pal_even (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head.idx_e),
    .wdata (head.rgb),
    .re    (pal_re),
    .raddr (head.idx_e),
    .rdata (even_q)
  );

  bmprle_ram #(
    .WIDTH (bmprle_pkg::RGB_W),
    .DEPTH (bmprle_pkg::PAL_DEPTH)
  ) u_pal_odd (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head.idx_e),
    .wdata (head.rgb),
    .re    (pal_re),
    .raddr (head.idx_o),
    .rdata (odd_q)
  );

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= head.addr;
      len_r  <= head.len;
      done_r <= (head.kind == bmprle_pkg::Q_DONE);
    end
  end

  // The RAM read data holds while the result waits, since no read is issued then.
  assign out_if.valid         = out_valid_r;
  assign out_if.start_address = addr_r;
  assign out_if.run_length    = done_r ? '0 : len_r;
  assign out_if.color_even    = done_r ? '0 : even_q;
  assign out_if.color_odd     = done_r ? '0 : odd_q;
  assign out_if.frame_done    = done_r;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for the BMP RLE8/RLE4 pixel decoder: directed cases, then random
// frames, checked word by word against a decoder mirror kept in this file.
// Depends on bmprle_pkg, the channel interfaces and bmp_rle_pixel_decoder_top.

module tb;

  localparam int          HALF_PERIOD   = 4;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          PHASE_ITEMS   = 90;
  localparam logic [1:0]  ACT_IGNORED   = 2'd3;

  typedef struct packed {
    logic [bmprle_pkg::ADDR_W-1:0] start_address;
    logic [bmprle_pkg::BYTE_W-1:0] run_length;
    logic [bmprle_pkg::RGB_W-1:0]  color_even;
    logic [bmprle_pkg::RGB_W-1:0]  color_odd;
    logic                          frame_done;
  } pixel_seg_t;

  logic clk;
  logic rst_n;

  bmprle_in_if  in_if ();
  bmprle_out_if out_if ();
  bmprle_cfg_if cfg_if ();

  bmp_rle_pixel_decoder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

  // Mirror of the decoder: registers, parse position and palette.
  logic                          reg_rle4;
  logic [bmprle_pkg::DIM_W-1:0]  reg_width;
  logic [bmprle_pkg::DIM_W-1:0]  reg_height;
  bmprle_pkg::phase_t            cur_phase;
  logic [bmprle_pkg::BYTE_W-1:0] held_b;
  logic [bmprle_pkg::BYTE_W-1:0] abs_left;
  logic                          pad_due;
  logic [bmprle_pkg::DIM_W-1:0]  col_pos;
  logic [bmprle_pkg::DIM_W-1:0]  row_pos;
  logic [bmprle_pkg::ADDR_W-1:0] pix_addr;
  logic                          frame_over;
  logic [bmprle_pkg::RGB_W-1:0]  pal_copy [bmprle_pkg::PAL_DEPTH];

  pixel_seg_t segments_due [$];

  int  fail_count;
  int  items_sent;
  int  cycle_count;
  int  rx_wait;
  int  rx_draw;
  bit  rx_calm;
  bit  tx_gaps;
  bit  hold_on;
  pixel_seg_t got_seg;
  pixel_seg_t want_seg;
  event hold_evt;

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------- mirror

  function automatic void clear_position();
    cur_phase  = bmprle_pkg::PH_FIRST;
    held_b     = '0;
    abs_left   = '0;
    pad_due    = 1'b0;
    col_pos    = '0;
    row_pos    = '0;
    pix_addr   = '0;
    frame_over = 1'b0;
  endfunction

  function automatic void expect_segment(logic [bmprle_pkg::ADDR_W-1:0] a,
                                         logic [bmprle_pkg::BYTE_W-1:0] len,
                                         logic [bmprle_pkg::RGB_W-1:0] ce,
                                         logic [bmprle_pkg::RGB_W-1:0] co,
                                         logic done);
    pixel_seg_t s;
    s.start_address = a;
    s.run_length    = len;
    s.color_even    = ce;
    s.color_odd     = co;
    s.frame_done    = done;
    segments_due.push_back(s);
  endfunction

  // Row and column are stored wrapped, but the frame-end test sees the full row.
  function automatic void move_to_pos(int unsigned nc, int unsigned nr);
    int unsigned p;
    col_pos = nc[bmprle_pkg::DIM_W-1:0];
    row_pos = nr[bmprle_pkg::DIM_W-1:0];
    p = 32'(row_pos) * 32'(reg_width) + 32'(col_pos);
    pix_addr = p[bmprle_pkg::ADDR_W-1:0];
    if (nr >= 32'(reg_height)) begin
      frame_over = 1'b1;
      cur_phase  = bmprle_pkg::PH_FIRST;
      expect_segment(pix_addr, '0, '0, '0, 1'b1);
    end
  endfunction

  function automatic void advance_run(logic [bmprle_pkg::BYTE_W-1:0] len,
                                      logic [bmprle_pkg::RGB_W-1:0] ce,
                                      logic [bmprle_pkg::RGB_W-1:0] co);
    expect_segment(pix_addr, len, ce, co, 1'b0);
    pix_addr = pix_addr + 24'(len);
    col_pos  = col_pos + 13'(len);
  endfunction

  function automatic void parse_stream_byte(logic [bmprle_pkg::BYTE_W-1:0] b);
    int unsigned t;
    logic [bmprle_pkg::BYTE_W-1:0] n;
    case (cur_phase)
      bmprle_pkg::PH_FIRST: begin
        held_b    = b;
        cur_phase = bmprle_pkg::PH_SECOND;
      end
      bmprle_pkg::PH_SECOND: begin
        cur_phase = bmprle_pkg::PH_FIRST;
        if (held_b != 0) begin
          if (reg_rle4)
            advance_run(held_b, pal_copy[{4'h0, b[7:4]}], pal_copy[{4'h0, b[3:0]}]);
          else
            advance_run(held_b, pal_copy[b], pal_copy[b]);
        end else if (b == bmprle_pkg::ESC_EOL) begin
          move_to_pos(0, 32'(row_pos) + 1);
        end else if (b == bmprle_pkg::ESC_EOB) begin
          frame_over = 1'b1;
          expect_segment(pix_addr, '0, '0, '0, 1'b1);
        end else if (b == bmprle_pkg::ESC_DELTA) begin
          cur_phase = bmprle_pkg::PH_DX;
        end else begin
          // An absolute run is padded when it takes an odd number of bytes.
          abs_left  = b;
          t         = 32'(b) + 1;
          pad_due   = reg_rle4 ? t[1] : b[0];
          cur_phase = bmprle_pkg::PH_ABS;
        end
      end
      bmprle_pkg::PH_DX: begin
        held_b    = b;
        cur_phase = bmprle_pkg::PH_DY;
      end
      bmprle_pkg::PH_DY: begin
        cur_phase = bmprle_pkg::PH_FIRST;
        move_to_pos(32'(col_pos) + 32'(held_b), 32'(row_pos) + 32'(b));
      end
      bmprle_pkg::PH_ABS: begin
        if (reg_rle4) begin
          n = (abs_left >= 2) ? 8'd2 : abs_left;
          advance_run(n, pal_copy[{4'h0, b[7:4]}], pal_copy[{4'h0, b[3:0]}]);
        end else begin
          n = 8'd1;
          advance_run(n, pal_copy[b], pal_copy[b]);
        end
        abs_left = abs_left - n;
        if (abs_left == 0)
          cur_phase = pad_due ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
      end
      bmprle_pkg::PH_PAD: begin
        pad_due   = 1'b0;
        cur_phase = bmprle_pkg::PH_FIRST;
      end
      default: cur_phase = bmprle_pkg::PH_FIRST;
    endcase
  endfunction

  function automatic void decode_word(logic [1:0] act, logic [bmprle_pkg::BYTE_W-1:0] b,
                                      logic [bmprle_pkg::PAL_AW-1:0] idx,
                                      logic [bmprle_pkg::RGB_W-1:0] rgb);
    if (act == bmprle_pkg::ACT_PAL)
      pal_copy[idx] = rgb;
    else if (act == bmprle_pkg::ACT_FRAME)
      clear_position();
    else if (act == bmprle_pkg::ACT_BYTE && !frame_over)
      parse_stream_byte(b);
  endfunction

  // ---------------------------------------------------------------- drivers

  // Called at a rising edge; returns at the edge where the word was accepted.
  // Valid is left high so that a back-to-back word needs no second assignment.
  task automatic send_word(logic [1:0] act, logic [bmprle_pkg::BYTE_W-1:0] b,
                           logic [bmprle_pkg::PAL_AW-1:0] idx,
                           logic [bmprle_pkg::RGB_W-1:0] rgb);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.stream_byte   <= b;
    in_if.palette_index <= idx;
    in_if.palette_rgb   <= rgb;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    decode_word(act, b, idx, rgb);
    if (act != ACT_IGNORED) items_sent++;
  endtask

  task automatic put_byte(logic [bmprle_pkg::BYTE_W-1:0] b);
    send_word(bmprle_pkg::ACT_BYTE, b, 8'($urandom), 24'($urandom));
  endtask

  task automatic put_pair(logic [bmprle_pkg::BYTE_W-1:0] b0,
                          logic [bmprle_pkg::BYTE_W-1:0] b1);
    put_byte(b0);
    put_byte(b1);
  endtask

  task automatic put_delta(logic [bmprle_pkg::BYTE_W-1:0] dx,
                           logic [bmprle_pkg::BYTE_W-1:0] dy);
    put_pair(8'd0, bmprle_pkg::ESC_DELTA);
    put_pair(dx, dy);
  endtask

  task automatic put_frame();
    send_word(bmprle_pkg::ACT_FRAME, 8'($urandom), 8'($urandom), 24'($urandom));
  endtask

  // Sender pause: nothing more is offered until every result is back and the
  // pipeline has had time to finish any word that gives no result.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bmprle_pkg::cfg_reg_t idx, logic [bmprle_pkg::DIM_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      bmprle_pkg::CFG_MODE:   reg_rle4   = val[0];
      bmprle_pkg::CFG_WIDTH:  reg_width  = val;
      bmprle_pkg::CFG_HEIGHT: reg_height = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic mode, logic [bmprle_pkg::DIM_W-1:0] w,
                          logic [bmprle_pkg::DIM_W-1:0] h);
    drain_results();
    write_reg(bmprle_pkg::CFG_MODE, {12'd0, mode});
    write_reg(bmprle_pkg::CFG_WIDTH, w);
    write_reg(bmprle_pkg::CFG_HEIGHT, h);
  endtask

  // Absolute run of n pixels with random data, plus its pad byte if needed.
  task automatic put_absolute(int n);
    int nbytes;
    nbytes = reg_rle4 ? (n + 1) / 2 : n;
    put_pair(8'd0, n[7:0]);
    repeat (nbytes) put_byte(8'($urandom));
    if (nbytes % 2 == 1) put_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------- receiver

  always begin
    @(hold_evt);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // A drawn wait of zero keeps ready high, so words can be taken back to back.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait      <= 0;
    end else if (hold_on) begin
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      rx_draw       = rx_calm ? 0 : $urandom_range(0, 10);
      rx_wait      <= rx_draw;
      out_if.ready <= (rx_draw == 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait      <= 0;
      out_if.ready <= 1'b1;
    end
  end

  // Each accepted word is checked against the oldest expected segment.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_seg.start_address = out_if.start_address;
      got_seg.run_length    = out_if.run_length;
      got_seg.color_even    = out_if.color_even;
      got_seg.color_odd     = out_if.color_odd;
      got_seg.frame_done    = out_if.frame_done;
      if (segments_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected word addr=%h len=%0d even=%h odd=%h done=%b", $realtime,
                   got_seg.start_address, got_seg.run_length, got_seg.color_even,
                   got_seg.color_odd, got_seg.frame_done);
      end else begin
        want_seg = segments_due.pop_front();
        if (got_seg.start_address !== want_seg.start_address ||
            got_seg.run_length    !== want_seg.run_length ||
            got_seg.color_even    !== want_seg.color_even ||
            got_seg.color_odd     !== want_seg.color_odd ||
            got_seg.frame_done    !== want_seg.frame_done) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch expected addr=%h len=%0d even=%h odd=%h done=%b",
                     $realtime, want_seg.start_address, want_seg.run_length,
                     want_seg.color_even, want_seg.color_odd, want_seg.frame_done);
            $display("%0t:          actual   addr=%h len=%0d even=%h odd=%h done=%b",
                     $realtime, got_seg.start_address, got_seg.run_length,
                     got_seg.color_even, got_seg.color_odd, got_seg.frame_done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_palette_load();
    send_word(bmprle_pkg::ACT_PAL, 8'($urandom), 8'd0, 24'h000000);
    for (int i = 1; i < bmprle_pkg::PAL_DEPTH - 1; i++)
      send_word(bmprle_pkg::ACT_PAL, 8'($urandom), i[7:0], 24'($urandom));
    send_word(bmprle_pkg::ACT_PAL, 8'($urandom), 8'd255, 24'hFFFFFF);
  endtask

  // Reset registers are RLE8, width 1, height 1, and no frame start was sent.
  task automatic test_before_frame_start();
    put_pair(8'd3, 8'h10);
    put_pair(8'd0, bmprle_pkg::ESC_EOL);
    put_byte(8'd5);
    drain_results();
  endtask

  task automatic test_rle8_escapes();
    set_regs(1'b0, 13'd4096, 13'd4096);
    put_frame();
    put_pair(8'd255, 8'hFF);
    put_pair(8'd1, 8'h00);
    put_pair(8'd0, 8'd3);
    put_byte(8'h00); put_byte(8'hFF); put_byte(8'h5A); put_byte(8'hA5);
    put_absolute(4);
    put_delta(8'd255, 8'd0);
    send_word(ACT_IGNORED, 8'($urandom), 8'($urandom), 24'($urandom));
    put_pair(8'd0, bmprle_pkg::ESC_EOL);
    put_pair(8'd2, 8'h80);
    put_pair(8'd0, bmprle_pkg::ESC_EOB);
    put_pair(8'd7, 8'h01);
    drain_results();
  endtask

  // The frame carries on across a mode write; each byte uses the mode it meets.
  task automatic test_mode_switch();
    put_frame();
    put_pair(8'd2, 8'h33);
    set_regs(1'b1, 13'd4096, 13'd4096);
    put_pair(8'd5, 8'hF0);
    put_absolute(5);
    put_absolute(3);
    put_pair(8'd1, 8'h0F);
    set_regs(1'b0, 13'd4096, 13'd4096);
    put_pair(8'd4, 8'hC3);
    put_pair(8'd0, bmprle_pkg::ESC_EOB);
    drain_results();
  endtask

  // Walk to the last pixel of a 4096 x 4096 frame, then run past the address
  // space and past the column range.
  task automatic test_address_wrap();
    put_frame();
    repeat (16) put_delta(8'd255, 8'd255);
    put_delta(8'd15, 8'd15);
    put_pair(8'd3, 8'h42);
    repeat (16) put_delta(8'd255, 8'd0);
    put_pair(8'd255, 8'h99);
    put_pair(8'd0, bmprle_pkg::ESC_EOL);
    drain_results();
  endtask

  task automatic test_zero_height();
    set_regs(1'b0, 13'd8, 13'd0);
    put_frame();
    put_pair(8'd2, 8'h11);
    put_pair(8'd0, bmprle_pkg::ESC_EOL);
    put_frame();
    put_delta(8'd3, 8'd0);
    put_frame();
    put_pair(8'd0, bmprle_pkg::ESC_EOB);
    put_byte(8'd9);
    drain_results();
  endtask

  // The receiver stalls for a long stretch while words keep coming, so the
  // internal queue fills and the input stalls.
  task automatic test_backpressure();
    set_regs(1'b0, 13'd64, 13'd64);
    tx_gaps = 1'b0;
    put_frame();
    -> hold_evt;
    repeat (30) begin
      put_pair(8'($urandom_range(1, 255)), 8'($urandom));
      send_word(bmprle_pkg::ACT_PAL, 8'($urandom), 8'($urandom), 24'($urandom));
    end
    drain_results();
    tx_gaps = 1'b1;
  endtask

  task automatic rand_frame(int n_ops);
    int k;
    put_frame();
    repeat (n_ops) begin
      if ($urandom_range(0, 79) == 0) tx_gaps = !tx_gaps;
      k = $urandom_range(0, 99);
      if (k < 40)
        put_pair(8'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                : $urandom_range(1, 16)),
                 8'($urandom));
      else if (k < 55)
        put_absolute(($urandom_range(0, 15) == 0) ? $urandom_range(3, 255)
                                                  : $urandom_range(3, 12));
      else if (k < 68)
        put_pair(8'd0, bmprle_pkg::ESC_EOL);
      else if (k < 78)
        put_delta(8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 6)),
                  8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 2)));
      else if (k < 82)
        put_pair(8'd0, bmprle_pkg::ESC_EOB);
      else if (k < 86)
        put_byte(8'($urandom));
      else if (k < 90)
        send_word(ACT_IGNORED, 8'($urandom), 8'($urandom), 24'($urandom));
      else if (k < 94)
        send_word(bmprle_pkg::ACT_PAL, 8'($urandom), 8'($urandom), 24'($urandom));
      else if (k < 97)
        put_frame();
      else
        send_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 24'($urandom));
    end
    if ($urandom_range(0, 1) == 0) put_pair(8'd0, bmprle_pkg::ESC_EOB);
  endtask

  task automatic test_random_decode();
    int target;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: set_regs(1'b0, 13'd1, 13'd1);
        1: set_regs(1'b1, 13'd4096, 13'd4096);
        2: set_regs(1'b0, 13'($urandom_range(2, 64)), 13'($urandom_range(1, 12)));
        3: set_regs(1'b1, 13'($urandom_range(1, 48)), 13'($urandom_range(1, 12)));
        4: set_regs(1'b0, 13'd4096, 13'd1);
        5: set_regs(1'b1, 13'd1, 13'd4096);
        6: set_regs(1'b1, 13'($urandom_range(1, 16)), 13'($urandom_range(1, 4)));
        default: set_regs(1'b0, 13'($urandom_range(1, 4096)),
                          13'($urandom_range(1, 4096)));
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) rand_frame($urandom_range(1, 24));
    end
    drain_results();
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.action         <= bmprle_pkg::ACT_PAL;
    in_if.stream_byte    <= '0;
    in_if.palette_index  <= '0;
    in_if.palette_rgb    <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= bmprle_pkg::CFG_MODE;
    cfg_if.data          <= '0;
    items_sent  = 0;
    tx_gaps     = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    reg_rle4   = 1'b0;
    reg_width  = 13'd1;
    reg_height = 13'd1;
    clear_position();
    @(posedge clk);

    test_palette_load();
    test_before_frame_start();
    test_rle8_escapes();
    test_mode_switch();
    test_address_wrap();
    test_zero_height();
    test_backpressure();
    test_random_decode();

    if (fail_count == 0 && segments_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
